/* src/sdaf_pkg.sv */
// Shared constants, types and state codes for the signed decimal ASCII formatter.
// No dependencies; imported by every module of the block.
package sdaf_pkg;

   localparam int VALUE_WIDTH = 32;
   // Decimal digits needed for a VALUE_WIDTH-bit magnitude (log10(2) ~ 0.30103).
   localparam int DIGITS      = (VALUE_WIDTH * 30103) / 100000 + 1;
   localparam int BCD_WIDTH   = 4 * DIGITS;
   localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH);
   localparam int IDX_WIDTH   = $clog2(DIGITS);

   localparam logic [CNT_WIDTH-1:0] CNT_LAST  = CNT_WIDTH'(VALUE_WIDTH - 1);
   localparam logic [IDX_WIDTH-1:0] IDX_FIRST = IDX_WIDTH'(DIGITS - 1);

   localparam logic [6:0] CHAR_ZERO  = 7'd48;
   localparam logic [6:0] CHAR_MINUS = 7'd45;

   localparam logic [3:0] BCD_ADJ_LIMIT = 4'd5;
   localparam logic [3:0] BCD_ADJ       = 4'd3;

   typedef struct packed {
      logic load;
      logic step;
   } conv_ctrl_type;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_CONV = 4'b0010,
      S_SIGN = 4'b0100,
      S_EMIT = 4'b1000
   } state_type;

endpackage

/* src/sdaf_bcd_conv.sv */
// Shift-add-3 binary to BCD unit: one bit per step, one adjust-and-shift per cycle.
// Depends on sdaf_pkg.
module sdaf_bcd_conv (
   input  logic                           clock,
   input  sdaf_pkg::conv_ctrl_type        ctrl,
   input  logic [sdaf_pkg::VALUE_WIDTH-1:0] load_value,
   input  logic [sdaf_pkg::IDX_WIDTH-1:0] digit_sel,
   output logic [3:0]                     digit
);
   import sdaf_pkg::*;

   logic [VALUE_WIDTH-1:0] bin_ff, bin_in;
   logic [BCD_WIDTH-1:0]   bcd_ff, bcd_in;
   logic [BCD_WIDTH-1:0]   adj;

   // add 3 to every digit of 5 or more, then shift one bit in
   always_comb begin
      adj = bcd_ff;
      for (int i = 0; i < DIGITS; i++) begin
         if (bcd_ff[i*4 +: 4] >= BCD_ADJ_LIMIT) begin
            adj[i*4 +: 4] = bcd_ff[i*4 +: 4] + BCD_ADJ;
         end
      end
      bcd_in = bcd_ff;
      bin_in = bin_ff;
      if (ctrl.load) begin
         bcd_in = '0;
         bin_in = load_value;
      end else if (ctrl.step) begin
         {bcd_in, bin_in} = {adj[BCD_WIDTH-2:0], bin_ff, 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      bcd_ff <= bcd_in;
      bin_ff <= bin_in;
   end

   assign digit = bcd_ff[digit_sel*4 +: 4];

endmodule

/* src/sdaf_out_stage.sv */
// Output register of the result channel: holds one character item under stall.
// Depends on sdaf_pkg.
module sdaf_out_stage (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  logic [6:0] push_char,
   input  logic       push_last,
   input  logic       rsp_stall,
   output logic       can_take,
   output logic       rsp_valid,
   output logic [6:0] rsp_ascii_char,
   output logic       rsp_last
);
   import sdaf_pkg::*;

   logic       valid_ff, valid_in;
   logic [6:0] char_ff;
   logic       last_ff;

   assign can_take = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (can_take) begin
         valid_in = push;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (can_take && push) begin
         char_ff <= push_char;
         last_ff <= push_last;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_ascii_char = char_ff;
   assign rsp_last       = last_ff;

endmodule

/* src/signed_decimal_ascii_formatter.sv */
// Signed decimal ASCII formatter, top level: sequencer around the shift-add-3 unit.
// Depends on sdaf_pkg, sdaf_bcd_conv and sdaf_out_stage.
//
// Takes one signed VALUE_WIDTH-bit integer per item and returns its decimal
// text, one ASCII character per result item, most significant digit first,
// with rsp_last set on the final character. Negative values get a leading
// '-', zero gives '0', and there are no leading zeros; the most negative
// value formats correctly. An item is accepted, then converted by
// VALUE_WIDTH (32) shift-add-3 steps in the BCD unit, one per magnitude
// bit; the sign follows when negative, and then each decimal digit
// position (10) in turn, most significant first, with leading zeros
// skipped. The BCD unit is iterated one bit per cycle, so req_stall stays
// high from acceptance until the final character has entered the output
// register; that register lets the next item be accepted while the final
// character still waits to be taken.
module signed_decimal_ascii_formatter (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic signed [sdaf_pkg::VALUE_WIDTH-1:0] req_value,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [6:0]                       rsp_ascii_char,
   output logic                             rsp_last
);
   import sdaf_pkg::*;

   state_type            state_ff, state_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [IDX_WIDTH-1:0] idx_ff, idx_in;
   logic                 neg_ff, neg_in;
   logic                 started_ff, started_in;

   conv_ctrl_type          conv_ctrl;
   logic [VALUE_WIDTH-1:0] magnitude;
   logic [3:0]             digit;
   logic                   can_take;
   logic                   push;
   logic [6:0]             push_char;
   logic                   push_last;
   logic                   accept;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);

   // unsigned magnitude: the most negative value maps onto itself
   assign magnitude = req_value[VALUE_WIDTH-1] ? (~req_value + 1'b1) : req_value;

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      idx_in     = idx_ff;
      neg_in     = neg_ff;
      started_in = started_ff;
      conv_ctrl  = '0;
      push       = 1'b0;
      push_char  = CHAR_ZERO + {3'b000, digit};
      push_last  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               conv_ctrl.load = 1'b1;
               neg_in         = req_value[VALUE_WIDTH-1];
               cnt_in         = '0;
               state_in       = S_CONV;
            end
         end
         S_CONV: begin
            conv_ctrl.step = 1'b1;
            cnt_in         = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               idx_in     = IDX_FIRST;
               started_in = 1'b0;
               state_in   = neg_ff ? S_SIGN : S_EMIT;
            end
         end
         S_SIGN: begin
            push_char = CHAR_MINUS;
            push      = can_take;
            if (can_take) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!started_ff && digit == 4'd0 && idx_ff != '0) begin
               // leading zero: drop it
               idx_in = idx_ff - 1'b1;
            end else if (can_take) begin
               push       = 1'b1;
               push_last  = (idx_ff == '0);
               started_in = 1'b1;
               if (idx_ff == '0) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in = idx_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff     <= cnt_in;
      idx_ff     <= idx_in;
      neg_ff     <= neg_in;
      started_ff <= started_in;
   end

   sdaf_bcd_conv u_conv (
      .clock      (clock),
      .ctrl       (conv_ctrl),
      .load_value (magnitude),
      .digit_sel  (idx_ff),
      .digit      (digit)
   );

   sdaf_out_stage u_out (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .push_char      (push_char),
      .push_last      (push_last),
      .rsp_stall      (rsp_stall),
      .can_take       (can_take),
      .rsp_valid      (rsp_valid),
      .rsp_ascii_char (rsp_ascii_char),
      .rsp_last       (rsp_last)
   );

endmodule

/* src/sdaf_checker.sv */
// Port-level checks for the signed decimal ASCII formatter, bound to the top level.
// Depends on sdaf_pkg and signed_decimal_ascii_formatter.
module sdaf_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_stall,
   input logic [sdaf_pkg::VALUE_WIDTH-1:0] req_value,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic [6:0]                       rsp_ascii_char,
   input logic                             rsp_last
);
   import sdaf_pkg::*;

   // a waiting input item keeps its value
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_value))
      else $error("input item changed under stall");

   // a held item keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_ascii_char) && $stable(rsp_last))
      else $error("result item changed under stall");

   // only '-' or a digit ever leaves the block
   a_char_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_ascii_char == CHAR_MINUS) ||
                    (rsp_ascii_char >= CHAR_ZERO && rsp_ascii_char <= CHAR_ZERO + 7'd9))
      else $error("illegal character");

   // the sign is never the final character
   a_sign_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ascii_char == CHAR_MINUS |-> !rsp_last)
      else $error("sign marked last");

   // the block is busy right after taking an item
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item taken during conversion");

endmodule

bind signed_decimal_ascii_formatter sdaf_checker u_sdaf_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_value      (req_value),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_ascii_char (rsp_ascii_char),
   .rsp_last       (rsp_last)
);

/* tb/sv/tb_top.sv */
// Testbench for signed_decimal_ascii_formatter: drives signed integers and checks
// the decimal text that comes back, one character per item, against a local predictor.
// Depends on sdaf_pkg and the signed_decimal_ascii_formatter RTL.
module tb_top;
   import sdaf_pkg::*;

   localparam int QUIET_LIMIT  = 2000;  // cycles with no item moving on either side
   localparam int DRAIN_CYCLES = 60;    // settle time after the last expected character

   // One expected character of formatted text.
   typedef struct {
      logic [6:0] ascii_char;
      logic       last;
   } text_char_type;

   logic                          clock     = 1'b0;
   logic                          reset     = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic signed [VALUE_WIDTH-1:0] req_value = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [6:0]                    rsp_ascii_char;
   logic                          rsp_last;

   text_char_type expected_text[$];   // characters predicted but not yet seen
   int         failures     = 0;
   int         quiet_cycles = 0;
   bit         calm         = 1'b0; // set to suppress idling on both sides

   signed_decimal_ascii_formatter DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_ascii_char (rsp_ascii_char),
      .rsp_last       (rsp_last)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // About 7 calls in 100 ask for a break, unless a calm stretch is running.
   function automatic bit take_break();
      return !calm && ($urandom_range(99) < 7);
   endfunction

   // Decimal text of one value: optional '-', then digits MSD first, last flag on the end.
   // Magnitude is taken unsigned at full width so the most negative value is exact.
   function automatic void predict_text(input logic signed [VALUE_WIDTH-1:0] value);
      logic [VALUE_WIDTH-1:0] mag;
      logic [3:0]             digit_lsd_first[20];
      int                     num_digits;
      text_char_type          c;
      mag        = value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;
      num_digits = 0;
      if (mag == 0) begin
         c.ascii_char = CHAR_ZERO;
         c.last       = 1'b1;
         expected_text.push_back(c);
         return;
      end
      while (mag != 0) begin
         digit_lsd_first[num_digits] = 4'(mag % 10);
         mag                         = mag / 10;
         num_digits++;
      end
      if (value[VALUE_WIDTH-1]) begin
         c.ascii_char = CHAR_MINUS;
         c.last       = 1'b0;
         expected_text.push_back(c);
      end
      for (int i = num_digits - 1; i >= 0; i--) begin
         c.ascii_char = CHAR_ZERO + 7'(digit_lsd_first[i]);
         c.last       = (i == 0);
         expected_text.push_back(c);
      end
   endfunction

   // Random value, mostly with a random digit count so short and long texts both show up.
   function automatic logic signed [VALUE_WIDTH-1:0] pick_value();
      longint unsigned        lo;
      longint unsigned        hi;
      int unsigned            num_digits;
      logic [VALUE_WIDTH-1:0] mag;
      case ($urandom_range(9))
         0: begin
            return $urandom;
         end
         1: begin
            if ($urandom_range(1))
               return 32'h7fff_ffff - $urandom_range(15);
            else
               return 32'h8000_0000 + $urandom_range(15);
         end
         default: begin
            num_digits = $urandom_range(10, 1);
            lo = 1;
            repeat (num_digits - 1) lo = lo * 10;
            hi = lo * 10 - 1;
            if (hi > 64'h7fff_ffff) hi = 64'h7fff_ffff;
            mag = $urandom_range(hi[31:0], lo[31:0]);
            return $urandom_range(1) ? -mag : mag;
         end
      endcase
   endfunction

   // Offer one item at the falling edge and hold it until the block takes it.
   // Idle cycles put noise on the value while valid is low.
   task automatic send_value(input logic signed [VALUE_WIDTH-1:0] value);
      @(negedge clock);
      while (take_break()) begin
         req_valid = 1'b0;
         req_value = $urandom;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_value = value;
      do @(posedge clock); while (!(req_valid && !req_stall));
      predict_text(value);
   endtask

   task automatic wait_drained();
      while (expected_text.size() != 0) @(posedge clock);
   endtask

   // Boundaries: zero, single digits, powers of ten, both ends of the range.
   task automatic test_directed_extremes();
      send_value(0);
      send_value(1);
      send_value(-1);
      send_value(9);
      send_value(-9);
      send_value(10);
      send_value(-10);
      send_value(99);
      send_value(100);
      send_value(-100);
      send_value(1000000007);       // interior zeros must not be dropped
      send_value(999999999);
      send_value(-999999999);
      send_value(1000000000);
      send_value(-1000000000);
      send_value(32'h7fff_ffff);
      send_value(32'h8000_0000);     // most negative: magnitude does not fit signed
      send_value(32'h8000_0001);
      send_value(32'h5555_5555);
      send_value(32'haaaa_aaaa);
   endtask

   task automatic test_random_values(input int count);
      repeat (count) send_value(pick_value());
   endtask

   // Sender holds off until every character has come back, then resumes.
   task automatic test_drain_pause();
      repeat (6) send_value(pick_value());
      @(negedge clock);
      req_valid = 1'b0;
      wait_drained();
      repeat (6) send_value(pick_value());
   endtask

   // Long stretch with no idling on either side.
   task automatic test_back_to_back(input int count);
      calm = 1'b1;
      repeat (count) send_value(pick_value());
      calm = 1'b0;
   endtask

   // Receiver stall, changed only at the falling edge.
   always @(negedge clock) rsp_stall <= take_break();

   // Every accepted character is matched against the oldest prediction.
   always @(posedge clock) begin : check_text
      text_char_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_text.size() == 0) begin
            $display("%0t: unexpected character: expected none, actual char %0d last %0d",
                     $time, rsp_ascii_char, rsp_last);
            failures++;
         end else begin
            want = expected_text.pop_front();
            if (rsp_ascii_char !== want.ascii_char) begin
               $display("%0t: ascii_char: expected %0d, actual %0d",
                        $time, want.ascii_char, rsp_ascii_char);
               failures++;
            end
            if (rsp_last !== want.last) begin
               $display("%0t: last: expected %0d, actual %0d", $time, want.last, rsp_last);
               failures++;
            end
         end
      end
   end

   // Watchdog: too long with no item moving on either channel ends the run.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("signed_decimal_ascii_formatter: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (10) @(negedge clock);
      reset = 1'b0;

      test_directed_extremes();
      test_random_values(100);
      test_drain_pause();
      test_back_to_back(30);
      test_random_values(100);

      @(negedge clock);
      req_valid = 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (failures == 0 && expected_text.size() == 0)
         $display("signed_decimal_ascii_formatter: match");
      else
         $display("signed_decimal_ascii_formatter: mismatch");
      $finish;
   end

endmodule
